// File: sv/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [10:0] RESET_WIDTH  = 11'd640;
    localparam logic [12:0] RESET_HEIGHT = 13'd480;

    localparam logic [21:0] SAT_LIMIT = 22'd65280;
    localparam logic [7:0]  EDGE_MAX  = 8'd255;

    typedef struct packed {
        logic       action;
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] blue_edge;
        logic [7:0] green_edge;
        logic [7:0] red_edge;
        logic       frame_end;
    } t_edge_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb [8:0] pix;
        logic       frame_end;
    } t_job;

    typedef enum logic [1:0] {
        FS_ACCEPT,
        FS_UPDATE,
        FS_EMIT
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_GRAD,
        BS_SQUARE,
        BS_ROOT,
        BS_ROUND,
        BS_OUT
    } t_back_state;

endpackage

// File: sv/sem_fifo.sv
// Small register queue between stages.
module sem_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: sv/sem_front.sv
// Front end: pixel intake, line stores, 3x3 window and border masking.
module sem_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  sem_pkg::t_pixel_in                i_in,
    output logic                              o_full,
    input  logic [$clog2(MAX_WIDTH):0]        i_width,
    input  logic [$clog2(MAX_HEIGHT+2)-1:0]   i_height,
    output logic                              o_job_push,
    output sem_pkg::t_job                     o_job,
    input  logic                              i_job_full
);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CXW = AW + 1;
    localparam int RXW = $clog2(MAX_HEIGHT + 2);

    sem_pkg::t_front_state r_st, n_st;

    sem_pkg::t_rgb r_upper  [MAX_WIDTH];
    sem_pkg::t_rgb r_middle [MAX_WIDTH];
    sem_pkg::t_rgb r_top_rd, r_mid_rd, r_data;
    sem_pkg::t_rgb r_win [9];

    logic [AW-1:0]  r_icol, n_icol;
    logic [RXW-1:0] r_irow, n_irow;
    logic [AW-1:0]  r_ocol, n_ocol;
    logic [RXW-1:0] r_orow, n_orow;

    logic [CXW-1:0] icol_x, ocol_x, acc_col_x;
    logic [AW-1:0]  acc_col;
    logic [RXW-1:0] acc_row;
    logic           beyond, take, wrap, ready, last;
    logic [2:0]     row_ok, col_ok;
    sem_pkg::t_rgb  in_pix;

    assign icol_x = {1'b0, r_icol};
    assign ocol_x = {1'b0, r_ocol};
    assign in_pix = '{red: i_in.red_in, green: i_in.green_in, blue: i_in.blue_in};

    // Column wrap left by a narrowed width is applied at intake.
    always_comb begin
        wrap      = (icol_x >= i_width);
        acc_col_x = wrap ? '0 : icol_x;
        acc_col   = acc_col_x[AW-1:0];
        acc_row   = (wrap && (r_irow <= i_height)) ? r_irow + 1'b1 : r_irow;
        beyond    = (acc_row >= i_height);
        take      = !(i_in.action && !beyond);
    end

    always_comb begin
        row_ok[0] = (r_orow >= RXW'(1)) && (r_orow <= i_height);
        row_ok[1] = (r_orow < i_height);
        row_ok[2] = ((r_orow + 1'b1) < i_height);
        col_ok[0] = (ocol_x >= CXW'(1)) && (ocol_x <= i_width);
        col_ok[1] = (ocol_x < i_width);
        col_ok[2] = ((ocol_x + 1'b1) < i_width);
        last      = ((r_orow >= i_height - 1'b1) && (ocol_x >= i_width - 1'b1))
                    || (r_orow >= i_height);
        ready     = (r_irow > RXW'(1)) || ((r_irow == RXW'(1)) && (r_icol != '0));
        for (int k = 0; k < 9; k++) begin
            o_job.pix[k] = (row_ok[k/3] && col_ok[k%3]) ? r_win[k] : '0;
        end
        o_job.frame_end = last;
    end

    always_comb begin
        n_st       = r_st;
        n_icol     = r_icol;
        n_irow     = r_irow;
        n_ocol     = r_ocol;
        n_orow     = r_orow;
        o_full     = (r_st != sem_pkg::FS_ACCEPT);
        o_job_push = 1'b0;
        case (r_st)
            sem_pkg::FS_ACCEPT: begin
                if (i_push) begin
                    n_icol = acc_col;
                    n_irow = acc_row;
                    if (take) begin
                        n_st = sem_pkg::FS_UPDATE;
                    end
                end
            end
            sem_pkg::FS_UPDATE: begin
                if ((icol_x + 1'b1) >= i_width) begin
                    n_icol = '0;
                    if (r_irow <= i_height) begin
                        n_irow = r_irow + 1'b1;
                    end
                end else begin
                    n_icol = r_icol + 1'b1;
                end
                n_st = ready ? sem_pkg::FS_EMIT : sem_pkg::FS_ACCEPT;
            end
            sem_pkg::FS_EMIT: begin
                if (!i_job_full) begin
                    o_job_push = 1'b1;
                    n_st       = sem_pkg::FS_ACCEPT;
                    if (last) begin
                        n_icol = '0;
                        n_irow = '0;
                        n_ocol = '0;
                        n_orow = '0;
                    end else if ((ocol_x + 1'b1) >= i_width) begin
                        n_ocol = '0;
                        n_orow = r_orow + 1'b1;
                    end else begin
                        n_ocol = r_ocol + 1'b1;
                    end
                end
            end
            default: begin
                n_st = sem_pkg::FS_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= sem_pkg::FS_ACCEPT;
            r_icol <= '0;
            r_irow <= '0;
            r_ocol <= '0;
            r_orow <= '0;
        end else begin
            r_st   <= n_st;
            r_icol <= n_icol;
            r_irow <= n_irow;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
        end
    end

    // Line stores: read on intake, write back in the update state that follows.
    always_ff @(posedge i_clk) begin
        if (r_st == sem_pkg::FS_ACCEPT && i_push && take) begin
            r_top_rd <= r_upper[acc_col];
            r_mid_rd <= r_middle[acc_col];
            r_data   <= beyond ? '0 : in_pix;
        end
        if (r_st == sem_pkg::FS_UPDATE) begin
            r_upper[r_icol]  <= r_mid_rd;
            r_middle[r_icol] <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_st == sem_pkg::FS_UPDATE) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_top_rd;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= r_mid_rd;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_data;
        end
    end
endmodule

// File: sv/sem_back.sv
// Back end: Sobel gradients, squared sum and rounded integer root per channel.
module sem_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_empty,
    input  sem_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_res_push,
    output sem_pkg::t_edge_out o_res,
    input  logic               i_res_full
);
    sem_pkg::t_back_state r_st, n_st;

    sem_pkg::t_job      r_job;
    logic signed [10:0] r_gx [3];
    logic signed [10:0] r_gy [3];
    logic [15:0]        r_rad [3];
    logic               r_sat [3];
    logic [8:0]         r_rem [3];
    logic [7:0]         r_root [3];
    logic [7:0]         r_edge [3];
    logic [2:0]         r_cnt;

    logic [23:0]        pw [9];
    logic [7:0]         v [9];
    logic [10:0]        gpx, gnx, gpy, gny;
    logic signed [10:0] gx_c [3];
    logic signed [10:0] gy_c [3];
    logic signed [21:0] sqx, sqy;
    logic [21:0]        ssum [3];
    logic [10:0]        rem_sh [3];
    logic [10:0]        trial [3];
    logic [8:0]         q [3];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            pw[k] = r_job.pix[k];
        end
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 9; k++) begin
                v[k] = pw[k][8*c +: 8];
            end
            gpx = {3'b0, v[2]} + {2'b0, v[5], 1'b0} + {3'b0, v[8]};
            gnx = {3'b0, v[0]} + {2'b0, v[3], 1'b0} + {3'b0, v[6]};
            gpy = {3'b0, v[6]} + {2'b0, v[7], 1'b0} + {3'b0, v[8]};
            gny = {3'b0, v[0]} + {2'b0, v[1], 1'b0} + {3'b0, v[2]};
            gx_c[c] = $signed(gpx - gnx);
            gy_c[c] = $signed(gpy - gny);
            sqx = r_gx[c] * r_gx[c];
            sqy = r_gy[c] * r_gy[c];
            ssum[c] = $unsigned(sqx) + $unsigned(sqy);
            rem_sh[c] = {r_rem[c], r_rad[c][15:14]};
            trial[c]  = {1'b0, r_root[c], 2'b01};
            q[c] = {1'b0, r_root[c]} + 9'({1'b0, r_root[c]} < r_rem[c]);
        end
    end

    assign o_res.blue_edge  = r_edge[0];
    assign o_res.green_edge = r_edge[1];
    assign o_res.red_edge   = r_edge[2];
    assign o_res.frame_end  = r_job.frame_end;

    always_comb begin
        n_st       = r_st;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_st)
            sem_pkg::BS_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_st      = sem_pkg::BS_GRAD;
                end
            end
            sem_pkg::BS_GRAD:   n_st = sem_pkg::BS_SQUARE;
            sem_pkg::BS_SQUARE: n_st = sem_pkg::BS_ROOT;
            sem_pkg::BS_ROOT: begin
                if (r_cnt == 3'd7) begin
                    n_st = sem_pkg::BS_ROUND;
                end
            end
            sem_pkg::BS_ROUND:  n_st = sem_pkg::BS_OUT;
            sem_pkg::BS_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_st       = sem_pkg::BS_IDLE;
                end
            end
            default: n_st = sem_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= sem_pkg::BS_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == sem_pkg::BS_ROOT) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        for (int c = 0; c < 3; c++) begin
            case (r_st)
                sem_pkg::BS_GRAD: begin
                    r_gx[c] <= gx_c[c];
                    r_gy[c] <= gy_c[c];
                end
                sem_pkg::BS_SQUARE: begin
                    r_sat[c]  <= (ssum[c] > sem_pkg::SAT_LIMIT);
                    r_rad[c]  <= ssum[c][15:0];
                    r_rem[c]  <= '0;
                    r_root[c] <= '0;
                end
                sem_pkg::BS_ROOT: begin
                    r_rad[c] <= {r_rad[c][13:0], 2'b00};
                    if (rem_sh[c] >= trial[c]) begin
                        r_rem[c]  <= 9'(rem_sh[c] - trial[c]);
                        r_root[c] <= {r_root[c][6:0], 1'b1};
                    end else begin
                        r_rem[c]  <= rem_sh[c][8:0];
                        r_root[c] <= {r_root[c][6:0], 1'b0};
                    end
                end
                sem_pkg::BS_ROUND: begin
                    r_edge[c] <= (r_sat[c] || q[c][8]) ? sem_pkg::EDGE_MAX : q[c][7:0];
                end
                default: begin
                end
            endcase
        end
    end
endmodule

// File: sv/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude on an RGB raster stream: top level.
// Intake takes each pixel or flush item through accept and update, and through emit when
// the item releases a result; a drain inside the frame stays in accept. A full job queue
// holds the release in emit. Each result passes gradient, square, 8 root steps and
// rounding; the back end takes a new job only after the current result is pushed.
// Synchronous active-low reset clears counters, window and queues; width and
// height return to 640 and 480. Line stores are not cleared.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  sem_pkg::t_pixel_in                  i_in,
    output logic                                o_full,
    output logic                                o_empty,
    input  logic                                i_pop,
    output sem_pkg::t_edge_out                  o_out,
    input  logic                                i_cfg_we,
    input  logic [sem_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int CXW = $clog2(MAX_WIDTH) + 1;
    localparam int RXW = $clog2(MAX_HEIGHT + 2);

    // Raw register values; clamping happens on use.
    logic [10:0] r_width_raw;
    logic [12:0] r_height_raw;

    logic [CXW-1:0] width_eff;
    logic [RXW-1:0] height_eff;

    logic               job_push, job_full, job_pop, job_empty;
    sem_pkg::t_job      job_in, job_out;
    logic               res_push, res_full;
    sem_pkg::t_edge_out res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_raw  <= sem_pkg::RESET_WIDTH;
            r_height_raw <= sem_pkg::RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sem_pkg::CFG_IMAGE_WIDTH:  r_width_raw  <= i_cfg_data[10:0];
                sem_pkg::CFG_IMAGE_HEIGHT: r_height_raw <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp size to 1..MAX.
    always_comb begin
        if (r_width_raw == '0) begin
            width_eff = CXW'(1);
        end else if (32'(r_width_raw) > 32'(MAX_WIDTH)) begin
            width_eff = CXW'(MAX_WIDTH);
        end else begin
            width_eff = CXW'(r_width_raw);
        end
        if (r_height_raw == '0) begin
            height_eff = RXW'(1);
        end else if (32'(r_height_raw) > 32'(MAX_HEIGHT)) begin
            height_eff = RXW'(MAX_HEIGHT);
        end else begin
            height_eff = RXW'(r_height_raw);
        end
    end

    // Intake, line stores and window.
    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_in       (i_in),
        .o_full     (o_full),
        .i_width    (width_eff),
        .i_height   (height_eff),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    // Hold masked windows between the two halves.
    sem_fifo #(
        .T     (sem_pkg::t_job),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // Gradient and magnitude.
    sem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // Result queue seen by the consumer.
    sem_fifo #(
        .T     (sem_pkg::t_edge_out),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_out),
        .o_empty (o_empty)
    );
endmodule

// File: sv/sem_checker.sv
// Port-level checks for the Sobel edge magnitude block, with bind.
module sem_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_push,
    input sem_pkg::t_pixel_in i_in,
    input logic               o_full,
    input logic               o_empty,
    input logic               i_pop,
    input sem_pkg::t_edge_out o_out
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> (o_empty && !o_full))
        else $error("reset did not clear queues");

    a_pixel_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !i_in.action) |=> o_full)
        else $error("pixel item did not start line-store update");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out)))
        else $error("waiting result changed");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_push  (i_push),
    .i_in    (i_in),
    .o_full  (o_full),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_out   (o_out)
);
